[src/ptpf_pkg.sv]
// Shared constants for the pulse trigger and peak finder.
// Holds register widths, configuration indexes, reset values, detector modes and parameter defaults.
// No dependencies.
`default_nettype none

package ptpf_pkg;

  // Default field widths for the sample and position paths.
  localparam int SAMPLE_BITS_DEFAULT = 24;
  localparam int INDEX_BITS_DEFAULT  = 16;

  // Configuration register widths.
  localparam int GAIN_BITS      = 12;
  localparam int LEVEL_BITS     = 23;
  localparam int PROD_BITS      = GAIN_BITS + LEVEL_BITS;
  localparam int CFG_DATA_BITS  = 23;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_LEVEL = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 12'd1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 23'd0;
  localparam logic [LEVEL_BITS-1:0] HYST_RESET  = 23'd0;

  // Detector modes.
  localparam logic [1:0] MODE_QUIET = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;

endpackage

`default_nettype wire

[src/pulse_trigger_peak_finder_top.sv]
// Pulse trigger and peak finder with hysteresis, top level.
// Depends on ptpf_pkg for widths, register indexes, reset values and mode codes.
//
// Usage:
//   Samples enter on the input channel (in_valid / in_stall, sample,
//   last_sample), one transfer per clock at most. The detector emits one
//   pulse result (rise_index, peak_index, fall_index, peak_height) on the
//   output channel (out_valid / out_stall) for each pulse that falls below
//   the release threshold. Configuration registers are written through
//   cfg_write, cfg_index and cfg_data while the block is idle.
//   Throughput is one sample per cycle while no result is stalled. The
//   sample that closes a pulse passes through the input register, and its
//   result is then held in the result register. The gain products are
//   registered from the configuration registers, so they are ready when the
//   first sample after a write reaches the compare stage.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall is raised until the result is taken.
//   Reset (rst, synchronous) empties the pipeline, restores the register
//   defaults and returns the detector to waiting for a quiet level at
//   position zero. in_stall is held high while rst is high.
`default_nettype none

module pulse_trigger_peak_finder_top #(
  parameter int SAMPLE_BITS = ptpf_pkg::SAMPLE_BITS_DEFAULT,
  parameter int INDEX_BITS  = ptpf_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port.
  input  logic                                  cfg_write,
  input  logic [ptpf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ptpf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // Sample channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic                                  last_sample,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [INDEX_BITS-1:0]                 rise_index,
  output logic [INDEX_BITS-1:0]                 peak_index,
  output logic [INDEX_BITS-1:0]                 fall_index,
  output logic signed [SAMPLE_BITS-1:0]         peak_height
);

  localparam int PROD_BITS = ptpf_pkg::PROD_BITS;
  localparam int WIDE_BITS = (SAMPLE_BITS > PROD_BITS) ? SAMPLE_BITS : PROD_BITS;
  localparam int CMP_BITS  = WIDE_BITS + 2;

  // Configuration registers.
  logic [ptpf_pkg::GAIN_BITS-1:0]  filter_gain;
  logic [ptpf_pkg::LEVEL_BITS-1:0] trigger_level;
  logic [ptpf_pkg::LEVEL_BITS-1:0] hysteresis;

  // Registered gain products.
  logic [PROD_BITS-1:0] arm_prod;
  logic [PROD_BITS-1:0] hyst_prod;

  // Input register.
  logic                          a_valid;
  logic signed [SAMPLE_BITS-1:0] a_sample;
  logic                          a_last;

  // Detector state.
  logic [1:0]                    mode;
  logic [1:0]                    mode_next;
  logic [INDEX_BITS-1:0]         position;
  logic [INDEX_BITS-1:0]         position_next;
  logic [INDEX_BITS-1:0]         rise_position;
  logic [INDEX_BITS-1:0]         rise_position_next;
  logic [INDEX_BITS-1:0]         peak_position;
  logic [INDEX_BITS-1:0]         peak_position_next;
  logic signed [SAMPLE_BITS-1:0] max_height;
  logic signed [SAMPLE_BITS-1:0] max_height_next;
  logic                          emit;

  // Compare operands.
  logic signed [CMP_BITS-1:0] s_ext;
  logic signed [CMP_BITS-1:0] arm_ext;
  logic signed [CMP_BITS-1:0] hyst_ext;
  logic signed [CMP_BITS-1:0] s_plus_hyst;
  logic                       at_arm;
  logic                       below_release;

  logic advance;

  // The pipeline moves unless a result is waiting at a stalled receiver.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = rst || !advance;

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain   <= ptpf_pkg::GAIN_RESET;
      trigger_level <= ptpf_pkg::LEVEL_RESET;
      hysteresis    <= ptpf_pkg::HYST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ptpf_pkg::REG_FILTER_GAIN:   filter_gain   <= cfg_data[ptpf_pkg::GAIN_BITS-1:0];
        ptpf_pkg::REG_TRIGGER_LEVEL: trigger_level <= cfg_data[ptpf_pkg::LEVEL_BITS-1:0];
        ptpf_pkg::REG_HYSTERESIS:    hysteresis    <= cfg_data[ptpf_pkg::LEVEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Threshold products, recomputed every cycle from the registers.
  always_ff @(posedge clk) begin
    arm_prod  <= PROD_BITS'(filter_gain) * PROD_BITS'(trigger_level);
    hyst_prod <= PROD_BITS'(filter_gain) * PROD_BITS'(hysteresis);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      a_sample <= sample;
      a_last   <= last_sample;
    end
  end

  // Threshold compares: the release test s < arm - hyst is done as s + hyst < arm.
  always_comb begin
    s_ext         = CMP_BITS'(a_sample);
    arm_ext       = signed'(CMP_BITS'(arm_prod));
    hyst_ext      = signed'(CMP_BITS'(hyst_prod));
    s_plus_hyst   = s_ext + hyst_ext;
    at_arm        = (s_ext >= arm_ext);
    below_release = (s_plus_hyst < arm_ext);
  end

  // Detector next state.
  always_comb begin
    mode_next          = mode;
    rise_position_next = rise_position;
    peak_position_next = peak_position;
    max_height_next    = max_height;
    emit               = 1'b0;

    case (mode)
      ptpf_pkg::MODE_IDLE: begin
        if (at_arm) begin
          mode_next          = ptpf_pkg::MODE_PULSE;
          rise_position_next = position;
          peak_position_next = position;
          max_height_next    = a_sample;
        end
      end
      ptpf_pkg::MODE_PULSE: begin
        if (below_release) begin
          emit      = 1'b1;
          mode_next = ptpf_pkg::MODE_IDLE;
        end else if (a_sample > max_height) begin
          peak_position_next = position;
          max_height_next    = a_sample;
        end
      end
      default: begin
        // Waiting for a quiet level; the unused code behaves the same way.
        if (below_release) begin
          mode_next = ptpf_pkg::MODE_IDLE;
        end else begin
          mode_next = ptpf_pkg::MODE_QUIET;
        end
      end
    endcase

    // Record end restarts the detector; otherwise the position saturates.
    if (a_last) begin
      mode_next     = ptpf_pkg::MODE_QUIET;
      position_next = '0;
    end else if (position != {INDEX_BITS{1'b1}}) begin
      position_next = position + INDEX_BITS'(1);
    end else begin
      position_next = position;
    end
  end

  // Detector state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ptpf_pkg::MODE_QUIET;
      position      <= '0;
      rise_position <= '0;
      peak_position <= '0;
      max_height    <= '0;
    end else if (advance && a_valid) begin
      mode          <= mode_next;
      position      <= position_next;
      rise_position <= rise_position_next;
      peak_position <= peak_position_next;
      max_height    <= max_height_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid && emit) begin
      rise_index  <= rise_position;
      peak_index  <= peak_position;
      fall_index  <= position;
      peak_height <= max_height;
    end
  end

endmodule

`default_nettype wire
